[rtl/spq_pkg.sv]
// spq_pkg: command codes and item types for the sorted priority queue.
// Used by sorted_priority_queue; depends on nothing.
package spq_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] item_handle;
		logic [7:0] priority_req;
	} cmd_item_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] popped_handle;
		logic [7:0] popped_priority;
		logic [4:0] count;
	} rsp_item_t;

endpackage

[rtl/spq_ram.sv]
// spq_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// Standalone; no package needed.
module spq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/sorted_priority_queue.sv]
// sorted_priority_queue: sorted insertion priority queue over one entry RAM.
// Depends on spq_pkg and spq_ram.
//
// Entries (handle, priority) sit in one RAM in descending priority order, front at
// address 0. A small sequencer walks the RAM through its single read port, one
// entry per cycle, shifting entries through the write port as it goes: insert walks
// from the tail toward the front, pop and remove walk from the front toward the
// tail. An insert, pop or remove on a queue of N entries reads all N entries before
// its result is loaded; clear and commands that fail at once (insert when full, pop
// or remove when empty) skip the walk. The next command is accepted in the cycle
// after the result is loaded, at the earliest. A result that is still stalled holds
// the sequencer before it loads the following result. One command is in flight at
// a time; the result register lets the next command enter while a result waits to
// be taken.
module sorted_priority_queue #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  spq_pkg::cmd_item_t    cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output spq_pkg::rsp_item_t    rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HW = HANDLE_BITS;
	localparam int DW = HW + 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	spq_pkg::cmd_t     cmd_q;
	logic [HW-1:0]     h_q;
	logic [7:0]        p_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     rd_idx_q;
	logic [CW-1:0]     rd_left_q;
	logic              v_s1;
	logic [AW-1:0]     idx_s1;
	logic              hit_q;
	logic              ok_q;
	logic [7:0]        ph_q;
	logic [7:0]        pp_q;
	logic              rsp_valid_q;
	spq_pkg::rsp_item_t rsp_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DW-1:0]     wr_data;
	logic [DW-1:0]     rd_data;
	logic [HW-1:0]     rd_h;
	logic [7:0]        rd_p;
	logic [HW+7:0]     h_ext;
	logic [HW+7:0]     rd_h_ext;
	logic [CW+4:0]     count_ext;
	logic              fwd;
	logic              accept;

	spq_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	assign rd_h      = rd_data[HW-1:0];
	assign rd_p      = rd_data[DW-1:HW];
	assign h_ext     = {{HW{1'b0}}, cmd.item_handle};
	assign rd_h_ext  = {8'b0, rd_h};
	assign count_ext = {5'b0, count_q};
	assign fwd       = (cmd_q != spq_pkg::CMD_INSERT);
	assign accept    = cmd_valid && !cmd_stall;

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// write port: shift in the walk; new entry goes in mid-walk or at the front
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		case (state_q)
			ST_WALK: begin
				if (v_s1) begin
					if (fwd) begin
						if (hit_q) begin
							wr_en   = 1'b1;
							wr_addr = idx_s1 - AW'(1);
						end
					end else if (!hit_q) begin
						wr_en   = 1'b1;
						wr_addr = idx_s1 + AW'(1);
						if (rd_p >= p_q) begin
							wr_data = {p_q, h_q};
						end
					end
				end
			end
			ST_FIN: begin
				if (!fwd && !hit_q) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = {p_q, h_q};
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= spq_pkg::CMD_INSERT;
			h_q         <= '0;
			p_q         <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_left_q   <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			hit_q       <= 1'b0;
			ok_q        <= 1'b0;
			ph_q        <= '0;
			pp_q        <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q     <= cmd.command;
						h_q       <= h_ext[HW-1:0];
						p_q       <= cmd.priority_req;
						hit_q     <= 1'b0;
						v_s1      <= 1'b0;
						ok_q      <= 1'b0;
						ph_q      <= '0;
						pp_q      <= '0;
						rd_left_q <= count_q;
						case (cmd.command)
							spq_pkg::CMD_INSERT: begin
								rd_idx_q <= AW'(count_q - CW'(1));
								if (count_q == CW'(DEPTH)) begin
									state_q <= ST_DONE;
								end else if (count_q == '0) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_WALK;
								end
							end
							spq_pkg::CMD_CLEAR: begin
								count_q <= '0;
								ok_q    <= 1'b1;
								state_q <= ST_DONE;
							end
							default: begin
								rd_idx_q <= '0;
								if (count_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_WALK;
								end
							end
						endcase
					end
				end
				ST_WALK: begin
					if (rd_left_q != '0) begin
						rd_left_q <= rd_left_q - CW'(1);
						rd_idx_q  <= fwd ? rd_idx_q + AW'(1) : rd_idx_q - AW'(1);
						v_s1      <= 1'b1;
						idx_s1    <= rd_idx_q;
					end else begin
						v_s1    <= 1'b0;
						state_q <= ST_FIN;
					end
					if (v_s1 && !hit_q) begin
						if (fwd) begin
							if (cmd_q == spq_pkg::CMD_POP) begin
								hit_q <= 1'b1;
								ph_q  <= rd_h_ext[7:0];
								pp_q  <= rd_p;
							end else if (rd_h == h_q) begin
								hit_q <= 1'b1;
							end
						end else if (rd_p >= p_q) begin
							hit_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (fwd) begin
						if (hit_q) begin
							count_q <= count_q - CW'(1);
							ok_q    <= 1'b1;
						end
					end else begin
						count_q <= count_q + CW'(1);
						ok_q    <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.ok              <= ok_q;
						rsp_q.popped_handle   <= ph_q;
						rsp_q.popped_priority <= pp_q;
						rsp_q.count           <= count_ext[4:0];
						rsp_valid_q           <= 1'b1;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[verif/spq_checker.sv]
// spq_checker: predicts the result of every accepted command and checks the rsp channel.
// Keeps its own copy of the sorted queue; depends on spq_pkg.
`timescale 1ns / 100ps
module spq_checker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  spq_pkg::cmd_item_t cmd,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  spq_pkg::rsp_item_t rsp,
	output int                 fail_count,
	output int                 pending_count,
	output int                 checked_count
);

	logic [7:0]         slot_handle [DEPTH];
	logic [7:0]         slot_prio [DEPTH];
	int                 held_entries;
	spq_pkg::rsp_item_t expected_rsps [$];

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic void close_gap(int at);
		for (int j = at; j + 1 < held_entries; j++) begin
			slot_handle[j] = slot_handle[j + 1];
			slot_prio[j]   = slot_prio[j + 1];
		end
		held_entries--;
	endfunction

	function automatic spq_pkg::rsp_item_t apply_command(spq_pkg::cmd_item_t c);
		spq_pkg::rsp_item_t r;
		int                 at;
		r  = '0;
		at = held_entries;
		case (c.command)
			spq_pkg::CMD_INSERT: begin
				if (held_entries < DEPTH) begin
					for (int i = 0; i < held_entries; i++) begin
						if (at == held_entries && slot_prio[i] < c.priority_req) begin
							at = i;
						end
					end
					for (int i = held_entries; i > at; i--) begin
						slot_handle[i] = slot_handle[i - 1];
						slot_prio[i]   = slot_prio[i - 1];
					end
					slot_handle[at] = c.item_handle;
					slot_prio[at]   = c.priority_req;
					held_entries++;
					r.ok = 1'b1;
				end
			end
			spq_pkg::CMD_POP: begin
				if (held_entries > 0) begin
					r.popped_handle   = slot_handle[0];
					r.popped_priority = slot_prio[0];
					close_gap(0);
					r.ok = 1'b1;
				end
			end
			spq_pkg::CMD_REMOVE: begin
				for (int i = 0; i < held_entries; i++) begin
					if (at == held_entries && slot_handle[i] == c.item_handle) begin
						at = i;
					end
				end
				if (at < held_entries) begin
					close_gap(at);
					r.ok = 1'b1;
				end
			end
			spq_pkg::CMD_CLEAR: begin
				held_entries = 0;
				r.ok = 1'b1;
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		r.count = 5'(held_entries);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spq_pkg::rsp_item_t want;
		if (!arst_n) begin
			held_entries = 0;
			expected_rsps.delete();
			fail_count    = 0;
			pending_count = 0;
			checked_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("item with nothing expected", 32'(rsp), 32'h0);
				end else begin
					want = expected_rsps.pop_front();
					checked_count++;
					if (rsp.ok !== want.ok)
						report_mismatch("ok", 32'(rsp.ok), 32'(want.ok));
					if (rsp.popped_handle !== want.popped_handle)
						report_mismatch("popped_handle", 32'(rsp.popped_handle),
							32'(want.popped_handle));
					if (rsp.popped_priority !== want.popped_priority)
						report_mismatch("popped_priority", 32'(rsp.popped_priority),
							32'(want.popped_priority));
					if (rsp.count !== want.count)
						report_mismatch("count", 32'(rsp.count), 32'(want.count));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				expected_rsps.push_back(apply_command(cmd));
			end
			pending_count = expected_rsps.size();
		end
	end

endmodule

[verif/testbench.sv]
// testbench: drives commands into sorted_priority_queue and stalls its results.
// Depends on spq_pkg, sorted_priority_queue and spq_checker, which does the checking.
`timescale 1ns / 100ps
module testbench;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	spq_pkg::cmd_item_t cmd       = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	spq_pkg::rsp_item_t rsp;

	int fail_count;
	int pending_count;
	int checked_count;

	int         burst_left = 0;
	int         n_insert   = 0;
	int         n_pop      = 0;
	int         n_remove   = 0;
	int         n_clear    = 0;
	logic [7:0] recent_handles [8] = '{default: 8'h00};
	int         recent_at  = 0;

	always #1 clk = ~clk;

	sorted_priority_queue #(.DEPTH(16), .HANDLE_BITS(8)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	spq_checker #(.DEPTH(16)) result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd           (cmd),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	function automatic spq_pkg::cmd_item_t make_cmd(spq_pkg::cmd_t c, logic [7:0] h,
		logic [7:0] p);
		spq_pkg::cmd_item_t it;
		it.command      = c;
		it.item_handle  = h;
		it.priority_req = p;
		return it;
	endfunction

	function automatic spq_pkg::cmd_item_t random_cmd(int insert_pct);
		spq_pkg::cmd_item_t it;
		int                 roll;
		roll = $urandom_range(0, 99);
		it.item_handle = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 1) == 1)
			it.priority_req = 8'($urandom_range(0, 255));
		else
			it.priority_req = {2'($urandom_range(0, 3)), 6'd0};
		if (roll < 2) begin
			it.command = spq_pkg::CMD_CLEAR;
		end else if (roll < 2 + insert_pct) begin
			it.command = spq_pkg::CMD_INSERT;
			if ($urandom_range(0, 5) == 0)
				it.item_handle = recent_handles[$urandom_range(0, 7)];
		end else if (roll % 2 == 0) begin
			it.command = spq_pkg::CMD_POP;
		end else begin
			it.command = spq_pkg::CMD_REMOVE;
			if ($urandom_range(0, 3) != 0)
				it.item_handle = recent_handles[$urandom_range(0, 7)];
		end
		return it;
	endfunction

	task automatic send_item(input spq_pkg::cmd_item_t it);
		int gap;
		cmd       <= it;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		case (it.command)
			spq_pkg::CMD_INSERT: begin
				n_insert++;
				recent_handles[recent_at] = it.item_handle;
				recent_at = (recent_at + 1) % 8;
			end
			spq_pkg::CMD_POP:    n_pop++;
			spq_pkg::CMD_REMOVE: n_remove++;
			default:             n_clear++;
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_valid <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic wait_all_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		burst_left = 0;
	endtask

	initial begin
		int insert_pct;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_cmd(spq_pkg::CMD_POP,    8'h00, 8'h00));
		send_item(make_cmd(spq_pkg::CMD_REMOVE, 8'h11, 8'h00));
		send_item(make_cmd(spq_pkg::CMD_CLEAR,  8'hFF, 8'hFF));
		send_item(make_cmd(spq_pkg::CMD_INSERT, 8'hFF, 8'hFF));
		send_item(make_cmd(spq_pkg::CMD_INSERT, 8'h00, 8'h00));
		send_item(make_cmd(spq_pkg::CMD_INSERT, 8'hA5, 8'h80));
		send_item(make_cmd(spq_pkg::CMD_INSERT, 8'h5A, 8'h80));
		send_item(make_cmd(spq_pkg::CMD_INSERT, 8'h00, 8'h7F));
		send_item(make_cmd(spq_pkg::CMD_REMOVE, 8'h00, 8'h00));
		send_item(make_cmd(spq_pkg::CMD_REMOVE, 8'h77, 8'h00));
		send_item(make_cmd(spq_pkg::CMD_POP,    8'h00, 8'h00));
		for (int i = 0; i < 13; i++) begin
			send_item(make_cmd(spq_pkg::CMD_INSERT, 8'(i * 19 + 3), 8'(i * 37)));
		end
		send_item(make_cmd(spq_pkg::CMD_INSERT, 8'hC3, 8'hFF));
		send_item(make_cmd(spq_pkg::CMD_CLEAR,  8'h00, 8'h00));
		send_item(make_cmd(spq_pkg::CMD_POP,    8'hFF, 8'hFF));
		wait_all_results();

		insert_pct = 50;
		for (int n = 0; n < 1800; n++) begin
			if (n % 60 == 0) begin
				case ($urandom_range(0, 2))
					0:       insert_pct = 25;
					1:       insert_pct = 50;
					default: insert_pct = 72;
				endcase
			end
			if (n % 450 == 449) wait_all_results();
			send_item(random_cmd(insert_pct));
		end

		wait_all_results();
		repeat (30) @(posedge clk);
		$display("Ran %0d commands: %0d insert, %0d pop, %0d remove, %0d clear.",
			n_insert + n_pop + n_remove + n_clear, n_insert, n_pop, n_remove, n_clear);
		$display("Compared %0d results, %0d mismatches.", checked_count, fail_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		int stretch;
		int stall_pct;
		int cycles;
		bit long_hold_done;
		cycles         = 0;
		long_hold_done = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!long_hold_done && cycles >= 2500) begin
				long_hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				cycles += 400;
			end
			stall_pct = 25 * $urandom_range(0, 3);
			stretch   = $urandom_range(10, 150);
			repeat (stretch) begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
				@(posedge clk);
				cycles++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
